// File: rtl/fmc_pkg.sv
// Shared types and constants of the four-lane memory coalescer.
`timescale 1ns / 1ps
`default_nettype none

package fmc_pkg;

	localparam int MAX_LANES  = 4;
	localparam int DEF_LANES  = 4;
	localparam int LINE_WORDS = 8;
	localparam int DATA_W     = 32;
	localparam int BE_W       = 4;
	localparam int WORD_IDX_W = $clog2(LINE_WORDS);
	localparam int LINE_OFF_W = WORD_IDX_W + 2;
	localparam int LINE_W     = DATA_W - LINE_OFF_W;

	typedef enum logic [1:0] {
		PH_COLLECT = 2'd0,
		PH_ISSUE   = 2'd1,
		PH_WAIT    = 2'd2
	} phase_t;

	// One step of the lane and memory side, as it enters the block.
	typedef struct packed {
		logic [7:0]  lane_flags;
		logic [15:0] lane_byte_enables;
		logic [63:0] addr_lanes_01;
		logic [63:0] addr_lanes_23;
		logic [63:0] store_lanes_01;
		logic [63:0] store_lanes_23;
		logic [1:0]  mem_handshake;
		logic [63:0] line_words_01;
		logic [63:0] line_words_23;
		logic [63:0] line_words_45;
		logic [63:0] line_words_67;
	} step_t;

	// What the block drives for one step.
	typedef struct packed {
		logic [3:0]  lane_ready;
		logic [5:0]  request_flags;
		logic [31:0] request_line_address;
		logic [31:0] request_byte_enables;
		logic [63:0] request_words_01;
		logic [63:0] request_words_23;
		logic [63:0] request_words_45;
		logic [63:0] request_words_67;
		logic [3:0]  reply_valid;
		logic [63:0] reply_data_01;
		logic [63:0] reply_data_23;
	} result_t;

	// One buffered lane request.
	typedef struct packed {
		logic              is_store;
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] word;
		logic [BE_W-1:0]   be;
	} lane_t;

	// The coalesced line request picked in Collect.
	typedef struct packed {
		logic                                  any;
		logic                                  is_store;
		logic [LINE_W-1:0]                     line;
		logic [MAX_LANES-1:0]                  mask;
		logic [MAX_LANES-1:0][WORD_IDX_W-1:0]  word_idx;
		logic [LINE_WORDS-1:0][DATA_W-1:0]     words;
		logic [LINE_WORDS*BE_W-1:0]            be;
	} sel_t;

endpackage

`default_nettype wire

// File: rtl/fmc_chan_if.sv
// Valid/ready channel that carries one payload per transaction.
`timescale 1ns / 1ps
`default_nettype none

interface fmc_chan_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: rtl/fmc_lane_buf.sv
// Per-lane request buffers: fill from free lanes, release on reply.
`timescale 1ns / 1ps
`default_nettype none

module fmc_lane_buf #(
	parameter int LANES = fmc_pkg::DEF_LANES
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire logic [fmc_pkg::MAX_LANES-1:0] req_valid,
	input  fmc_pkg::lane_t              req_lanes [fmc_pkg::MAX_LANES],
	input  wire logic [fmc_pkg::MAX_LANES-1:0] free,
	output logic [fmc_pkg::MAX_LANES-1:0]      full,
	output fmc_pkg::lane_t              lanes [fmc_pkg::MAX_LANES]
);

	for (genvar l = 0; l < fmc_pkg::MAX_LANES; l++) begin : g_lane
		if (l < LANES) begin : g_real
			logic                           full_q;
			logic                           store_q;
			logic [fmc_pkg::DATA_W-1:0]     addr_q;
			logic [fmc_pkg::DATA_W-1:0]     word_q;
			logic [fmc_pkg::BE_W-1:0]       be_q;
			logic                           take;

			// A request is only taken by a lane that was empty at the start of the step.
			assign take = load && req_valid[l] && !full_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					full_q  <= 1'b0;
					store_q <= 1'b0;
				end else if (load) begin
					if (take) begin
						full_q  <= 1'b1;
						store_q <= req_lanes[l].is_store;
					end else if (free[l]) begin
						full_q <= 1'b0;
					end
				end
			end

			always_ff @(posedge clk) begin
				if (take) begin
					addr_q <= req_lanes[l].addr;
					word_q <= req_lanes[l].word;
					be_q   <= req_lanes[l].be;
				end
			end

			assign full[l]           = full_q;
			assign lanes[l].is_store = store_q;
			assign lanes[l].addr     = addr_q;
			assign lanes[l].word     = word_q;
			assign lanes[l].be       = be_q;
		end else begin : g_absent
			assign full[l]  = 1'b0;
			assign lanes[l] = '0;
		end
	end

endmodule

`default_nettype wire

// File: rtl/fmc_select.sv
// Collect logic: seed lane, matching lanes and the merged store line.
`timescale 1ns / 1ps
`default_nettype none

module fmc_select (
	input  wire logic [fmc_pkg::MAX_LANES-1:0] full,
	input  fmc_pkg::lane_t              lanes [fmc_pkg::MAX_LANES],
	output fmc_pkg::sel_t               sel
);

	always_comb begin
		logic                          found;
		logic [fmc_pkg::MAX_LANES-1:0] match;
		logic [fmc_pkg::LINE_WORDS-1:0] claimed;

		found   = 1'b0;
		match   = '0;
		claimed = '0;
		sel     = '0;

		// The lowest full lane sets line and direction.
		for (int l = 0; l < fmc_pkg::MAX_LANES; l++) begin
			if (full[l] && !found) begin
				found        = 1'b1;
				sel.is_store = lanes[l].is_store;
				sel.line     = lanes[l].addr[fmc_pkg::DATA_W-1:fmc_pkg::LINE_OFF_W];
			end
		end
		sel.any = found;

		for (int l = 0; l < fmc_pkg::MAX_LANES; l++) begin
			match[l] = found && full[l]
				&& (lanes[l].addr[fmc_pkg::DATA_W-1:fmc_pkg::LINE_OFF_W] == sel.line)
				&& (lanes[l].is_store == sel.is_store);
			if (match[l]) begin
				sel.word_idx[l] = lanes[l].addr[fmc_pkg::LINE_OFF_W-1:2];
			end
		end
		sel.mask = match;

		// For stores the lowest lane that addresses a word owns it.
		for (int w = 0; w < fmc_pkg::LINE_WORDS; w++) begin
			for (int l = 0; l < fmc_pkg::MAX_LANES; l++) begin
				if (match[l] && sel.is_store && !claimed[w]
					&& (sel.word_idx[l] == fmc_pkg::WORD_IDX_W'(w))) begin
					claimed[w]                       = 1'b1;
					sel.words[w]                     = lanes[l].word;
					sel.be[w*fmc_pkg::BE_W +: fmc_pkg::BE_W] = lanes[l].be;
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/four_lane_memory_coalescer.sv
// Top level of the four-lane memory coalescer.
// A step transaction's result passes through the input register, then the result register,
// and is offered on the result channel from there.
// Throughput: one step per cycle; the only limit is backpressure on the result channel.
// A stalled result holds in the result register while the input register keeps the next step.
// Reset (arst_n low, asynchronous): phase to Collect, all lane buffers empty, held request cleared,
// both pipeline stages empty. No clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module four_lane_memory_coalescer #(
	parameter int LANES = fmc_pkg::DEF_LANES
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	fmc_chan_if.sink    step,
	fmc_chan_if.source  result
);

	localparam logic [fmc_pkg::MAX_LANES-1:0] LANE_MASK =
		fmc_pkg::MAX_LANES'((1 << LANES) - 1);

	// Pipeline: step_s1 holds the accepted step, result_s2 holds the finished result.
	// A step is processed (state updated, result captured) when stage 1 holds one and
	// the result register is empty or being emptied in the same cycle.
	fmc_pkg::step_t   step_s1;
	logic             valid_s1;
	fmc_pkg::result_t result_s2;
	logic             valid_s2;
	logic             advance;

	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign step.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (step.ready) begin
			valid_s1 <= step.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step.ready && step.valid) begin
			step_s1 <= step.data;
		end
	end

	// Split the stored step into per-lane requests and response words.
	fmc_pkg::lane_t                                       req_lanes [fmc_pkg::MAX_LANES];
	logic [fmc_pkg::LINE_WORDS-1:0][fmc_pkg::DATA_W-1:0] line_words;

	always_comb begin
		req_lanes[0].addr = step_s1.addr_lanes_01[31:0];
		req_lanes[1].addr = step_s1.addr_lanes_01[63:32];
		req_lanes[2].addr = step_s1.addr_lanes_23[31:0];
		req_lanes[3].addr = step_s1.addr_lanes_23[63:32];
		req_lanes[0].word = step_s1.store_lanes_01[31:0];
		req_lanes[1].word = step_s1.store_lanes_01[63:32];
		req_lanes[2].word = step_s1.store_lanes_23[31:0];
		req_lanes[3].word = step_s1.store_lanes_23[63:32];
		for (int l = 0; l < fmc_pkg::MAX_LANES; l++) begin
			req_lanes[l].is_store = step_s1.lane_flags[4 + l];
			req_lanes[l].be       = step_s1.lane_byte_enables[l*fmc_pkg::BE_W +: fmc_pkg::BE_W];
		end
	end

	assign line_words = {step_s1.line_words_67, step_s1.line_words_45,
		step_s1.line_words_23, step_s1.line_words_01};

	// Lane buffers and the Collect selection over their contents at the start of the step.
	logic [fmc_pkg::MAX_LANES-1:0] full;
	logic [fmc_pkg::MAX_LANES-1:0] free;
	fmc_pkg::lane_t                lanes [fmc_pkg::MAX_LANES];
	fmc_pkg::sel_t                 sel;

	fmc_lane_buf #(
		.LANES (LANES)
	) u_lane_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.req_valid (step_s1.lane_flags[fmc_pkg::MAX_LANES-1:0]),
		.req_lanes (req_lanes),
		.free      (free),
		.full      (full),
		.lanes     (lanes)
	);

	fmc_select u_select (
		.full  (full),
		.lanes (lanes),
		.sel   (sel)
	);

	// Phase sequencer: Collect picks a line, Issue waits for the memory accept,
	// Wait holds until the response arrives and the replies go out.
	fmc_pkg::phase_t phase_q;
	fmc_pkg::phase_t phase_d;
	fmc_pkg::sel_t   held_q;
	logic            load_held;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			fmc_pkg::PH_COLLECT: begin
				if (sel.any) phase_d = fmc_pkg::PH_ISSUE;
			end
			fmc_pkg::PH_ISSUE: begin
				if (step_s1.mem_handshake[0]) phase_d = fmc_pkg::PH_WAIT;
			end
			fmc_pkg::PH_WAIT: begin
				if (step_s1.mem_handshake[1]) phase_d = fmc_pkg::PH_COLLECT;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	fmc_pkg::result_t                              result_d;
	logic [fmc_pkg::MAX_LANES-1:0][fmc_pkg::DATA_W-1:0] reply;

	always_comb begin
		result_d  = '0;
		free      = '0;
		reply     = '0;
		load_held = 1'b0;
		result_d.lane_ready = ~full & LANE_MASK;
		unique case (phase_q)
			fmc_pkg::PH_COLLECT: begin
				load_held = sel.any;
			end
			fmc_pkg::PH_ISSUE: begin
				result_d.request_flags        = {held_q.mask, held_q.is_store, 1'b1};
				result_d.request_line_address = {held_q.line, fmc_pkg::LINE_OFF_W'(0)};
				result_d.request_byte_enables = held_q.be;
				result_d.request_words_01     = {held_q.words[1], held_q.words[0]};
				result_d.request_words_23     = {held_q.words[3], held_q.words[2]};
				result_d.request_words_45     = {held_q.words[5], held_q.words[4]};
				result_d.request_words_67     = {held_q.words[7], held_q.words[6]};
			end
			fmc_pkg::PH_WAIT: begin
				// Every lane in the held mask gets its reply and frees its buffer.
				if (step_s1.mem_handshake[1]) begin
					free                 = held_q.mask;
					result_d.reply_valid = held_q.mask;
					for (int l = 0; l < fmc_pkg::MAX_LANES; l++) begin
						if (held_q.mask[l] && !held_q.is_store) begin
							reply[l] = line_words[held_q.word_idx[l]];
						end
					end
				end
			end
			default: begin
				load_held = 1'b0;
			end
		endcase
		result_d.reply_data_01 = {reply[1], reply[0]};
		result_d.reply_data_23 = {reply[3], reply[2]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= fmc_pkg::PH_COLLECT;
			held_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			if (load_held) begin
				held_q <= sel;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_d;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

`ifndef SYNTHESIS
	// Lanes of the outstanding line request stay buffered until their reply.
	a_held_lanes_full: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != fmc_pkg::PH_COLLECT) |-> ((held_q.mask & ~full) == '0))
		else $error("held lane is not buffered");

	// An issued or pending line request always serves at least one lane.
	a_held_mask_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == fmc_pkg::PH_ISSUE || phase_q == fmc_pkg::PH_WAIT) |-> (held_q.mask != '0))
		else $error("line request without lanes");

	// A reply only goes to a lane that was holding a request.
	a_reply_to_busy_lane: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((result_s2.reply_valid & result_s2.lane_ready) == '0))
		else $error("reply to an empty lane");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the four-lane memory coalescer.
`timescale 1ns / 1ps

module tb;

	localparam int LANES          = fmc_pkg::DEF_LANES;
	localparam int STORE_FLAG_LSB = 4;   // lane_flags bits 7:4 mark a store
	localparam int MEM_ACCEPT     = 0;   // mem_handshake bit: memory takes the line request
	localparam int MEM_RSP_VALID  = 1;   // mem_handshake bit: memory response is valid
	localparam int RANDOM_STEPS   = 1250;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int DRAIN_CYCLES   = 16;

	// Step-by-step copy of the coalescer. Each accepted step transaction advances it by one step
	// and leaves the result that the block owes for that step in a queue.
	class coalescer_scoreboard;
		fmc_pkg::phase_t                                         phase;
		bit [fmc_pkg::MAX_LANES-1:0]                             full;
		bit [fmc_pkg::MAX_LANES-1:0]                             store;
		bit [fmc_pkg::MAX_LANES-1:0][fmc_pkg::DATA_W-1:0]        addr;
		bit [fmc_pkg::MAX_LANES-1:0][fmc_pkg::DATA_W-1:0]        store_word;
		bit [fmc_pkg::MAX_LANES-1:0][fmc_pkg::BE_W-1:0]          enables;
		bit                                                      held_store;
		bit [fmc_pkg::LINE_W-1:0]                                held_line;
		bit [fmc_pkg::MAX_LANES-1:0]                             held_mask;
		bit [fmc_pkg::MAX_LANES-1:0][fmc_pkg::WORD_IDX_W-1:0]    held_idx;
		bit [fmc_pkg::LINE_WORDS-1:0][fmc_pkg::DATA_W-1:0]       held_words;
		bit [fmc_pkg::LINE_WORDS*fmc_pkg::BE_W-1:0]              held_be;
		fmc_pkg::result_t                                        expected_results[$];
		int                                                      failures;

		function new();
			phase      = fmc_pkg::PH_COLLECT;
			full       = '0;
			store      = '0;
			addr       = '0;
			store_word = '0;
			enables    = '0;
			held_store = 1'b0;
			held_line  = '0;
			held_mask  = '0;
			held_idx   = '0;
			held_words = '0;
			held_be    = '0;
			failures   = 0;
		endfunction

		function void note_step(fmc_pkg::step_t s);
			fmc_pkg::result_t                                      r;
			int                                                    seed;
			bit                                                    sel_store;
			bit [fmc_pkg::LINE_W-1:0]                              sel_line;
			bit [fmc_pkg::MAX_LANES-1:0]                           sel_mask;
			bit [fmc_pkg::MAX_LANES-1:0][fmc_pkg::WORD_IDX_W-1:0]  sel_idx;
			bit [fmc_pkg::LINE_WORDS-1:0][fmc_pkg::DATA_W-1:0]     sel_words;
			bit [fmc_pkg::LINE_WORDS*fmc_pkg::BE_W-1:0]            sel_be;
			bit [fmc_pkg::LINE_WORDS-1:0]                          claimed;
			bit [fmc_pkg::WORD_IDX_W-1:0]                          w;
			bit [fmc_pkg::MAX_LANES-1:0][fmc_pkg::DATA_W-1:0]      in_addr;
			bit [fmc_pkg::MAX_LANES-1:0][fmc_pkg::DATA_W-1:0]      in_word;
			bit [fmc_pkg::LINE_WORDS-1:0][fmc_pkg::DATA_W-1:0]     line;
			bit [fmc_pkg::MAX_LANES-1:0][fmc_pkg::DATA_W-1:0]      reply;

			r         = '0;
			seed      = -1;
			sel_store = 1'b0;
			sel_line  = '0;
			sel_mask  = '0;
			sel_idx   = '0;
			sel_words = '0;
			sel_be    = '0;
			claimed   = '0;
			reply     = '0;
			in_addr   = {s.addr_lanes_23, s.addr_lanes_01};
			in_word   = {s.store_lanes_23, s.store_lanes_01};
			line      = {s.line_words_67, s.line_words_45, s.line_words_23, s.line_words_01};

			for (int l = 0; l < LANES; l++) begin
				if (!full[l])
					r.lane_ready[l] = 1'b1;
				else if (seed < 0)
					seed = l;
			end

			if (phase == fmc_pkg::PH_ISSUE) begin
				r.request_flags        = {held_mask, held_store, 1'b1};
				r.request_line_address = {held_line, {fmc_pkg::LINE_OFF_W{1'b0}}};
				r.request_byte_enables = held_be;
				{r.request_words_67, r.request_words_45,
				 r.request_words_23, r.request_words_01} = held_words;
			end

			// Selection works on the buffers as they were at the start of the step.
			if (phase == fmc_pkg::PH_COLLECT && seed >= 0) begin
				sel_store = store[seed];
				sel_line  = addr[seed][fmc_pkg::DATA_W-1:fmc_pkg::LINE_OFF_W];
				for (int l = 0; l < LANES; l++) begin
					if (!full[l] || store[l] != sel_store ||
					    addr[l][fmc_pkg::DATA_W-1:fmc_pkg::LINE_OFF_W] != sel_line)
						continue;
					sel_mask[l] = 1'b1;
					w           = addr[l][fmc_pkg::LINE_OFF_W-1:2];
					sel_idx[l]  = w;
					if (sel_store && !claimed[w]) begin
						claimed[w]   = 1'b1;
						sel_words[w] = store_word[l];
						sel_be[w*fmc_pkg::BE_W +: fmc_pkg::BE_W] = enables[l];
					end
				end
			end

			for (int l = 0; l < LANES; l++) begin
				if (s.lane_flags[l] && !full[l]) begin
					full[l]       = 1'b1;
					store[l]      = s.lane_flags[l + STORE_FLAG_LSB];
					addr[l]       = in_addr[l];
					store_word[l] = in_word[l];
					enables[l]    = s.lane_byte_enables[l*fmc_pkg::BE_W +: fmc_pkg::BE_W];
				end
			end

			case (phase)
				fmc_pkg::PH_COLLECT: begin
					if (seed >= 0) begin
						held_store = sel_store;
						held_line  = sel_line;
						held_mask  = sel_mask;
						held_idx   = sel_idx;
						held_words = sel_words;
						held_be    = sel_be;
						phase      = fmc_pkg::PH_ISSUE;
					end
				end
				fmc_pkg::PH_ISSUE: begin
					if (s.mem_handshake[MEM_ACCEPT])
						phase = fmc_pkg::PH_WAIT;
				end
				fmc_pkg::PH_WAIT: begin
					if (s.mem_handshake[MEM_RSP_VALID]) begin
						for (int l = 0; l < LANES; l++) begin
							if (!held_mask[l])
								continue;
							r.reply_valid[l] = 1'b1;
							reply[l]         = held_store ? '0 : line[held_idx[l]];
							full[l]          = 1'b0;
						end
						phase = fmc_pkg::PH_COLLECT;
					end
				end
				default: ;
			endcase

			{r.reply_data_23, r.reply_data_01} = reply;
			expected_results.push_back(r);
		endfunction

		function void compare_field(string name, bit [63:0] want, logic [63:0] got);
			if (got !== want) begin
				$error("%s: expected %h, actual %h", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(fmc_pkg::result_t got);
			fmc_pkg::result_t want;

			if (expected_results.size() == 0) begin
				$error("result transaction arrived with no step waiting for it");
				failures++;
				return;
			end
			want = expected_results.pop_front();
			compare_field("lane_ready", want.lane_ready, got.lane_ready);
			compare_field("request_flags", want.request_flags, got.request_flags);
			compare_field("request_line_address", want.request_line_address,
			              got.request_line_address);
			compare_field("request_byte_enables", want.request_byte_enables,
			              got.request_byte_enables);
			compare_field("request_words_01", want.request_words_01, got.request_words_01);
			compare_field("request_words_23", want.request_words_23, got.request_words_23);
			compare_field("request_words_45", want.request_words_45, got.request_words_45);
			compare_field("request_words_67", want.request_words_67, got.request_words_67);
			compare_field("reply_valid", want.reply_valid, got.reply_valid);
			compare_field("reply_data_01", want.reply_data_01, got.reply_data_01);
			compare_field("reply_data_23", want.reply_data_23, got.reply_data_23);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	fmc_chan_if #(.payload_t(fmc_pkg::step_t))   step_ch ();
	fmc_chan_if #(.payload_t(fmc_pkg::result_t)) result_ch ();

	four_lane_memory_coalescer #(
		.LANES(LANES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.step(step_ch),
		.result(result_ch)
	);

	coalescer_scoreboard sb = new();

	// A few line bases that the random lanes aim at, so that lanes often share a line and
	// coalesce. The set is refreshed now and then.
	bit [fmc_pkg::DATA_W-1:0] hot_lines [4];
	int                       steps_sent;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap before each transaction on either side. Every fourth stretch of 64 transactions
	// runs without any gaps so that back-to-back traffic is covered too.
	function automatic int idle_cycles(int n);
		return ((n / 64) % 4 == 3) ? 0 : int'($urandom_range(0, 17));
	endfunction

	// One step with the given lane requests and handshake; the response line is always random
	// so that any reply word picked from the wrong slot shows up.
	function automatic fmc_pkg::step_t compose(bit [7:0] flags, bit [15:0] be, bit [63:0] a01,
	                                           bit [63:0] a23, bit [63:0] d01, bit [63:0] d23,
	                                           bit [1:0] hs);
		fmc_pkg::step_t s;

		s.lane_flags        = flags;
		s.lane_byte_enables = be;
		s.addr_lanes_01     = a01;
		s.addr_lanes_23     = a23;
		s.store_lanes_01    = d01;
		s.store_lanes_23    = d23;
		s.mem_handshake     = hs;
		s.line_words_01     = {$urandom, $urandom};
		s.line_words_23     = {$urandom, $urandom};
		s.line_words_45     = {$urandom, $urandom};
		s.line_words_67     = {$urandom, $urandom};
		return s;
	endfunction

	// Random step with mostly well-formed content: lanes usually hit one of the hot lines and
	// usually agree on direction, while a fraction of addresses is fully random.
	function automatic fmc_pkg::step_t random_step();
		bit [7:0]                                         flags;
		bit [fmc_pkg::MAX_LANES-1:0][fmc_pkg::DATA_W-1:0] a;
		bit [fmc_pkg::MAX_LANES-1:0][fmc_pkg::DATA_W-1:0] d;

		flags[3:0] = 4'($urandom_range(0, 15));
		if ($urandom_range(0, 9) < 7)
			flags[7:4] = {4{1'($urandom_range(0, 1))}};
		else
			flags[7:4] = 4'($urandom_range(0, 15));
		for (int l = 0; l < fmc_pkg::MAX_LANES; l++) begin
			if ($urandom_range(0, 4) == 0)
				a[l] = $urandom;
			else
				a[l] = hot_lines[$urandom_range(0, 3)] | $urandom_range(0, 31);
			d[l] = $urandom;
		end
		return compose(flags, 16'($urandom_range(0, 65535)), a[1:0], a[3:2], d[1:0], d[3:2],
		               2'($urandom_range(0, 3)));
	endfunction

	function automatic void refresh_hot_lines();
		for (int i = 0; i < 3; i++)
			hot_lines[i] = $urandom & ~32'd31;
		hot_lines[3] = $urandom_range(0, 1) ? 32'hFFFF_FFE0 : 32'h0;
	endfunction

	// Offer one step transaction, hold it until it is taken, and let the scoreboard see it.
	// When no gap follows, valid simply stays high and the next payload takes over.
	task automatic send_step(input fmc_pkg::step_t s);
		int gap;

		gap = idle_cycles(steps_sent);
		if (gap > 0) begin
			step_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		step_ch.valid <= 1'b1;
		step_ch.data  <= s;
		do @(posedge clk); while (!step_ch.ready);
		sb.note_step(s);
		steps_sent++;
	endtask

	// Hand-picked opening: an empty step with a stray accept and response, a full load line,
	// requests to lanes that are still busy, stalls in Issue and Wait, stores that all hit the
	// top word of the last line (the lowest lane must win), and a mix of directions and lines
	// that has to drain in three separate memory requests.
	task automatic directed_steps();
		send_step(compose(8'h00, 16'h0000, '0, '0, '0, '0, 2'b11));
		send_step(compose(8'h0F, 16'hFFFF, {32'h0000_0004, 32'h0000_0000},
		                  {32'h0000_001C, 32'h0000_0008}, '1, '1, 2'b00));
		send_step(compose(8'hFF, 16'hFFFF, '1, '1, '1, '1, 2'b00));
		send_step(compose(8'h00, 16'h0000, '0, '0, '0, '0, 2'b10));
		send_step(compose(8'h00, 16'h0000, '0, '0, '0, '0, 2'b01));
		send_step(compose(8'h00, 16'h0000, '0, '0, '0, '0, 2'b01));
		send_step(compose(8'hFF, 16'h8421, '1, '1, '1, '1, 2'b10));
		send_step(compose(8'hFF, 16'h8421, {32'hFFFF_FFFF, 32'hFFFF_FFFC},
		                  {32'hFFFF_FFFD, 32'hFFFF_FFFE},
		                  {32'h2222_2222, 32'h1111_1111},
		                  {32'h4444_4444, 32'h3333_3333}, 2'b00));
		send_step(compose(8'h00, 16'h0000, '0, '0, '0, '0, 2'b11));
		send_step(compose(8'h00, 16'h0000, '0, '0, '0, '0, 2'b01));
		send_step(compose(8'h00, 16'h0000, '0, '0, '0, '0, 2'b10));
		send_step(compose(8'h2F, 16'h5A5A, {32'h1000_0010, 32'h1000_0004},
		                  {32'h1000_001F, 32'h2000_0000},
		                  {32'hCAFE_0001, 32'hCAFE_0000},
		                  {32'hCAFE_0003, 32'hCAFE_0002}, 2'b00));
		repeat (10)
			send_step(compose(8'h00, 16'h0000, '0, '0, '0, '0, 2'b11));
	endtask

	// Result side: draw a stall before each result, then check whatever the block hands over.
	initial begin
		int stall;
		int results_taken;

		results_taken = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_cycles(results_taken);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			sb.check_result(result_ch.data);
			results_taken++;
		end
	end

	// Watchdog: too long without a transaction on either channel means the block is stuck.
	initial begin
		int quiet;

		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((step_ch.valid && step_ch.ready) || (result_ch.valid && result_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("four_lane_memory_coalescer verification failed");
		$finish;
	end

	// Main sequence: reset once, the directed opening, the random body, then drain.
	initial begin
		steps_sent = 0;
		arst_n        <= 1'b0;
		step_ch.valid <= 1'b0;
		step_ch.data  <= '0;
		refresh_hot_lines();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_steps();
		for (int n = 0; n < RANDOM_STEPS; n++) begin
			if (n % 50 == 0)
				refresh_hot_lines();
			send_step(random_step());
		end
		step_ch.valid <= 1'b0;

		// Every step owes exactly one result, so the queue runs dry once all have come back.
		// The drain that follows then catches any stray extra result.
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.failures == 0)
			$display("four_lane_memory_coalescer verification clean");
		else
			$display("four_lane_memory_coalescer verification failed");
		$finish;
	end

endmodule
